// File: hdl/thkr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package thkr_pkg;

  // Table geometry.
  localparam int KEY_SLOTS = 32;
  localparam int IDX_W     = $clog2(KEY_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

  // Input function codes.
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_PRESS   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  // Key kinds, as given at press and as resolved.
  localparam logic [2:0] KIND_NORMAL     = 3'd0;
  localparam logic [2:0] KIND_NORMAL_MOD = 3'd1;
  localparam logic [2:0] KIND_DUAL       = 3'd4;
  localparam logic [2:0] KIND_TAP        = 3'd5;
  localparam logic [2:0] KIND_REPEAT     = 3'd6;
  localparam logic [2:0] KIND_HOLD       = 3'd7;

  // Slot states held in the table.
  localparam logic [2:0] KS_IDLE     = 3'd0;
  localparam logic [2:0] KS_PRESSED  = 3'd1;
  localparam logic [2:0] KS_TAP      = 3'd2;
  localparam logic [2:0] KS_RELEASED = 3'd3;
  localparam logic [2:0] KS_REPEAT   = 3'd4;

  // Change codes of a result.
  localparam logic [1:0] CHG_PRESSED  = 2'd0;
  localparam logic [1:0] CHG_RELEASED = 2'd1;
  localparam logic [1:0] CHG_HOLD     = 2'd2;

  // Configuration register indexes.
  localparam logic REG_HOLD_TIMEOUT   = 1'b0;
  localparam logic REG_REPEAT_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] key_slot;
    logic [2:0] key_kind;
    logic [7:0] key_code;
  } thkr_in_t;

  typedef struct packed {
    logic [4:0] out_slot;
    logic [1:0] change_kind;
    logic [2:0] resolved_kind;
    logic [1:0] key_status;
    logic       emit;
    logic [5:0] held_count;
    logic       last_of_run;
  } thkr_out_t;

  // One table entry.
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] kind;
    logic [7:0] press_time;
    logic [7:0] code;
  } thkr_entry_t;

  // Requests from the sequencer to the result buffer.
  typedef struct packed {
    logic push;
    logic flush;
  } thkr_obuf_ctl_t;

  // Status of the result buffer.
  typedef struct packed {
    logic can_push;
    logic pend_vld;
    logic out_free;
  } thkr_obuf_st_t;

  // Reported status is the slot state minus one.
  function automatic logic [1:0] status_code(input logic [2:0] st);
    logic [2:0] t;
    t = st - 3'd1;
    return t[1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/thkr_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module thkr_out_buf (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  thkr_pkg::thkr_obuf_ctl_t ctl_i,
  input  thkr_pkg::thkr_out_t      push_res_i,
  output thkr_pkg::thkr_obuf_st_t  st_o,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output thkr_pkg::thkr_out_t      out_data_o
);
  import thkr_pkg::*;

  logic      out_vld_q, out_vld_d;
  logic      pend_vld_q, pend_vld_d;
  thkr_out_t out_q, out_d;
  thkr_out_t pend_q, pend_d;
  logic      out_free;
  logic      can_push;

  // A result is held back one step so that the last one of a run can be marked.
  assign out_free = !out_vld_q || out_ready_i;
  assign can_push = !pend_vld_q || out_free;

  assign st_o.can_push = can_push;
  assign st_o.pend_vld = pend_vld_q;
  assign st_o.out_free = out_free;

  always_comb begin
    out_vld_d  = out_vld_q && !out_ready_i;
    out_d      = out_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    if (ctl_i.push && can_push) begin
      if (pend_vld_q) begin
        out_vld_d         = 1'b1;
        out_d             = pend_q;
        out_d.last_of_run = 1'b0;
      end
      pend_vld_d = 1'b1;
      pend_d     = push_res_i;
    end else if (ctl_i.flush && pend_vld_q && out_free) begin
      out_vld_d         = 1'b1;
      out_d             = pend_q;
      out_d.last_of_run = 1'b1;
      pend_vld_d        = 1'b0;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Result payloads.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hdl/tap_hold_key_resolver.sv
`timescale 1ns / 1ps
`default_nettype none

// Dual-role key resolver. Press, release and tick beats enter on the input
// channel one at a time; each beat gives zero or more result beats, the last
// one flagged by last_of_run. The slot table lives in one synchronous memory
// with a single read and a single write port, and every conversion of
// undecided dual keys walks that table one slot per cycle unless a result
// cannot be pushed and the scan stalls. A tick, a non-dual press and a tap
// release walk the table; a dual press, any other release, an ignored press
// or release and an unused function do not. Results already finished wait
// in an output register while the next beat is accepted. The hold and repeat
// timeouts are written through the register port at byte addresses 0 and 4
// and must be changed only while the block is idle.

module tap_hold_key_resolver (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Event input.
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  thkr_pkg::thkr_in_t  in_data_i,
  // Result output.
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output thkr_pkg::thkr_out_t out_data_o,
  // Register port.
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import thkr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOKUP = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_PRESS  = 3'd3;
  localparam logic [2:0] S_FINAL  = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [7:0]       hold_to_q, rep_to_q;
  logic [7:0]       time_q, time_d;
  logic [5:0]       held_keys_q, held_keys_d;
  logic [5:0]       held_duals_q, held_duals_d;
  logic [7:0]       last_rel_q, last_rel_d;
  logic [7:0]       last_tap_q, last_tap_d;
  logic             tap_seen_q, tap_seen_d;

  logic [1:0]       func_q, func_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [2:0]       kind_q, kind_d;
  logic [7:0]       code_q, code_d;
  thkr_out_t        fin_q, fin_d;

  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic             issue_q, issue_d;
  logic             ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0] ev_idx_q, ev_idx_d;
  logic [7:0]       limit_q, limit_d;
  logic             skip_en_q, skip_en_d;

  // Slot table and its written flags.
  thkr_entry_t      mem [KEY_SLOTS];
  thkr_entry_t      rdata_q;
  logic [KEY_SLOTS-1:0] written_q;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  thkr_entry_t      mem_wdata;

  thkr_obuf_ctl_t   obuf_ctl;
  thkr_obuf_st_t    obuf_st;
  thkr_out_t        push_res;

  logic             in_acc;
  logic             in_slot_ok;
  logic             cfg_wr;
  thkr_entry_t      ent_lk, ent_ev;
  logic [7:0]       lk_age, ev_age;
  logic             lk_busy, lk_undecided;
  logic             ev_hit, ev_stall;
  logic             rep_hit;
  logic [2:0]       pr_status, pr_kind;
  logic [5:0]       pr_duals;
  thkr_out_t        hit_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_slot_ok = (32'(in_data_i.key_slot) < KEY_SLOTS);

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_HOLD_TIMEOUT:   prdata = {24'd0, hold_to_q};
      REG_REPEAT_TIMEOUT: prdata = {24'd0, rep_to_q};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_to_q <= 8'd3;
      rep_to_q  <= 8'd3;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HOLD_TIMEOUT) begin
        hold_to_q <= pwdata[7:0];
      end else begin
        rep_to_q <= pwdata[7:0];
      end
    end
  end

  // Table entries never written read as idle slots.
  always_comb begin
    ent_lk = rdata_q;
    if (!written_q[slot_q]) begin
      ent_lk.status = KS_IDLE;
    end
    ent_ev = rdata_q;
    if (!written_q[ev_idx_q]) begin
      ent_ev.status = KS_IDLE;
    end
  end

  assign lk_age       = time_q - ent_lk.press_time;
  assign ev_age       = time_q - ent_ev.press_time;
  assign lk_busy      = (ent_lk.status == KS_PRESSED) || (ent_lk.status == KS_REPEAT);
  assign lk_undecided = (ent_lk.status == KS_PRESSED) && (ent_lk.kind == KIND_DUAL);

  // Scan stage: an undecided dual whose age reaches the limit turns into a hold key.
  assign ev_hit = ev_vld_q && !(skip_en_q && (ev_idx_q == slot_q))
                  && (ent_ev.status == KS_PRESSED) && (ent_ev.kind == KIND_DUAL)
                  && (ev_age >= limit_q);
  assign ev_stall = ev_hit && !obuf_st.can_push;

  always_comb begin
    hit_res               = '0;
    hit_res.out_slot      = 5'(ev_idx_q);
    hit_res.change_kind   = CHG_HOLD;
    hit_res.resolved_kind = KIND_HOLD;
    hit_res.key_status    = status_code(KS_PRESSED);
    hit_res.held_count    = held_keys_q;
  end

  // Press resolution: a dual press of the last released code, within the repeat timeout of the last tap, repeats.
  assign rep_hit = (kind_q == KIND_DUAL) && tap_seen_q && (last_rel_q == code_q)
                   && ((time_q - last_tap_q) < rep_to_q);
  assign pr_status = rep_hit ? KS_REPEAT : KS_PRESSED;
  assign pr_kind   = rep_hit ? KIND_REPEAT : kind_q;
  assign pr_duals  = held_duals_q + 6'((kind_q == KIND_DUAL) && !rep_hit);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    held_keys_d  = held_keys_q;
    held_duals_d = held_duals_q;
    last_rel_d   = last_rel_q;
    last_tap_d   = last_tap_q;
    tap_seen_d   = tap_seen_q;
    func_d       = func_q;
    slot_d       = slot_q;
    kind_d       = kind_q;
    code_d       = code_q;
    fin_d        = fin_q;
    ridx_d       = ridx_q;
    issue_d      = issue_q;
    ev_vld_d     = ev_vld_q;
    ev_idx_d     = ev_idx_q;
    limit_d      = limit_q;
    skip_en_d    = skip_en_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_q;
    mem_wdata    = ent_lk;
    mem_re       = 1'b0;
    mem_raddr    = ridx_q;
    obuf_ctl     = '0;
    push_res     = fin_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d    = in_data_i.func;
          slot_d    = IDX_W'(in_data_i.key_slot);
          kind_d    = (in_data_i.key_kind > KIND_DUAL) ? KIND_NORMAL : in_data_i.key_kind;
          code_d    = in_data_i.key_code;
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(in_data_i.key_slot);
          ridx_d    = '0;
          issue_d   = 1'b1;
          ev_vld_d  = 1'b0;
          unique case (in_data_i.func)
            FUNC_TICK: begin
              time_d    = time_q + 8'd1;
              limit_d   = hold_to_q;
              skip_en_d = 1'b0;
              state_d   = S_SCAN;
            end
            FUNC_PRESS, FUNC_RELEASE: begin
              if (in_slot_ok) begin
                state_d = S_LOOKUP;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_LOOKUP: begin
        limit_d = 8'd0;
        if (func_q == FUNC_PRESS) begin
          if (lk_busy) begin
            state_d = S_IDLE;
          end else if (kind_q != KIND_DUAL) begin
            skip_en_d = 1'b0;
            state_d   = S_SCAN;
          end else begin
            state_d = S_PRESS;
          end
        end else if (!lk_busy) begin
          state_d = S_IDLE;
        end else begin
          // Release of a held slot; a tap also converts the other duals.
          last_rel_d          = ent_lk.code;
          held_keys_d         = held_keys_q - 6'(held_keys_q != '0);
          mem_we              = 1'b1;
          mem_wdata.status    = KS_RELEASED;
          fin_d               = '0;
          fin_d.out_slot      = 5'(slot_q);
          fin_d.change_kind   = CHG_RELEASED;
          fin_d.resolved_kind = ent_lk.kind;
          fin_d.key_status    = status_code(KS_RELEASED);
          fin_d.held_count    = held_keys_d;
          state_d             = S_FINAL;
          if (lk_undecided) begin
            held_duals_d = held_duals_q - 6'(held_duals_q != '0);
            if (lk_age < hold_to_q) begin
              mem_wdata.status    = KS_TAP;
              mem_wdata.kind      = KIND_TAP;
              fin_d.resolved_kind = KIND_TAP;
              fin_d.key_status    = status_code(KS_TAP);
              fin_d.emit          = 1'b1;
              last_tap_d          = time_q;
              tap_seen_d          = 1'b1;
              skip_en_d           = 1'b1;
              state_d             = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // Write back a converted entry and report it.
        if (ev_hit && obuf_st.can_push) begin
          mem_we         = 1'b1;
          mem_waddr      = ev_idx_q;
          mem_wdata      = ent_ev;
          mem_wdata.kind = KIND_HOLD;
          held_duals_d   = held_duals_q - 6'(held_duals_q != '0);
          obuf_ctl.push  = 1'b1;
          push_res       = hit_res;
        end
        // Read the next slot unless the scan stage is stalled.
        if (!ev_stall) begin
          if (issue_q) begin
            mem_re    = 1'b1;
            mem_raddr = ridx_q;
            ev_vld_d  = 1'b1;
            ev_idx_d  = ridx_q;
            ridx_d    = ridx_q + IDX_W'(1);
            issue_d   = (ridx_q != LAST_IDX);
          end else begin
            ev_vld_d = 1'b0;
          end
        end
        if (!issue_q && !ev_vld_q) begin
          unique case (func_q)
            FUNC_TICK:  state_d = S_FLUSH;
            FUNC_PRESS: state_d = S_PRESS;
            default:    state_d = S_FINAL;
          endcase
        end
      end

      S_PRESS: begin
        held_keys_d          = held_keys_q + 6'd1;
        held_duals_d         = pr_duals;
        mem_we               = 1'b1;
        mem_wdata.status     = pr_status;
        mem_wdata.kind       = pr_kind;
        mem_wdata.press_time = time_q;
        mem_wdata.code       = code_q;
        fin_d                = '0;
        fin_d.out_slot       = 5'(slot_q);
        fin_d.change_kind    = CHG_PRESSED;
        fin_d.resolved_kind  = pr_kind;
        fin_d.key_status     = status_code(pr_status);
        fin_d.emit           = (pr_duals == '0) && (rep_hit || (pr_kind == KIND_NORMAL)
                               || (pr_kind == KIND_NORMAL_MOD));
        fin_d.held_count     = held_keys_d;
        state_d              = S_FINAL;
      end

      S_FINAL: begin
        if (obuf_st.can_push) begin
          obuf_ctl.push = 1'b1;
          state_d       = S_FLUSH;
        end
      end

      S_FLUSH: begin
        obuf_ctl.flush = 1'b1;
        if (!obuf_st.pend_vld || obuf_st.out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      time_q       <= '0;
      held_keys_q  <= '0;
      held_duals_q <= '0;
      last_rel_q   <= '0;
      last_tap_q   <= '0;
      tap_seen_q   <= 1'b0;
      issue_q      <= 1'b0;
      ev_vld_q     <= 1'b0;
      written_q    <= '0;
    end else begin
      state_q      <= state_d;
      time_q       <= time_d;
      held_keys_q  <= held_keys_d;
      held_duals_q <= held_duals_d;
      last_rel_q   <= last_rel_d;
      last_tap_q   <= last_tap_d;
      tap_seen_q   <= tap_seen_d;
      issue_q      <= issue_d;
      ev_vld_q     <= ev_vld_d;
      if (mem_we) begin
        written_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // Item and scan payload.
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    slot_q    <= slot_d;
    kind_q    <= kind_d;
    code_q    <= code_d;
    fin_q     <= fin_d;
    ridx_q    <= ridx_d;
    ev_idx_q  <= ev_idx_d;
    limit_q   <= limit_d;
    skip_en_q <= skip_en_d;
  end

  // Slot table memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  thkr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (obuf_ctl),
    .push_res_i  (push_res),
    .st_o        (obuf_st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_tap_hold_key_resolver.sv
`timescale 1ns / 1ps

module tb_tap_hold_key_resolver;
  import thkr_pkg::*;

  // Codes without a name in the package.
  localparam logic [1:0] FUNC_NONE     = 2'd3;
  localparam logic [2:0] KIND_MODIFIER = 3'd2;
  localparam logic [2:0] KIND_LAYER    = 3'd3;

  // Reported key status of a result beat.
  localparam logic [1:0] RS_PRESSED  = 2'd0;
  localparam logic [1:0] RS_TAP      = 2'd1;
  localparam logic [1:0] RS_RELEASED = 2'd2;
  localparam logic [1:0] RS_REPEAT   = 2'd3;

  localparam int        IDLE_PCT        = 24;
  localparam int        SETTLE_CYCLES   = 64;
  localparam int        HOLD_OFF_CYCLES = 400;
  localparam int        LIMIT_CYCLES    = 400000;
  localparam thkr_out_t NO_RESULT       = '0;

  // One directed row: the event, and its single result where it is typed in.
  typedef struct packed {
    thkr_in_t  ev;
    logic      typed;
    thkr_out_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  thkr_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  thkr_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the key table and of the timing state.
  logic [2:0] key_state [KEY_SLOTS];
  logic [2:0] key_kind_tbl [KEY_SLOTS];
  logic [7:0] key_stamp [KEY_SLOTS];
  logic [7:0] key_code_tbl [KEY_SLOTS];
  logic [7:0] now_ticks;
  int         keys_down;
  int         open_duals;
  logic [7:0] released_code;
  logic [7:0] last_tap_tick;
  logic       tapped;
  logic [7:0] hold_limit;
  logic [7:0] repeat_limit;

  thkr_out_t  run_changes[$];
  thkr_out_t  pending_changes[$];
  dir_row_t   dir_rows[$];

  int errors;
  int cycle_count;
  int hold_off_left;
  bit tx_idle;
  bit rx_idle;

  tap_hold_key_resolver uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record one change of slot s, taking kind and state from the shadow table.
  function automatic void note_change(input int s, input logic [1:0] chg, input logic emit);
    thkr_out_t  r;
    logic [2:0] st;
    st              = key_state[s] - 3'd1;
    r.out_slot      = 5'(s);
    r.change_kind   = chg;
    r.resolved_kind = key_kind_tbl[s];
    r.key_status    = st[1:0];
    r.emit          = emit;
    r.held_count    = 6'(keys_down);
    r.last_of_run   = 1'b0;
    run_changes.push_back(r);
  endfunction

  // Turn every undecided dual, other than slot skip, whose age reaches limit
  // into a hold key, in slot order.
  function automatic void promote_duals(input logic [7:0] limit, input int skip);
    logic [7:0] age;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      age = now_ticks - key_stamp[i];
      if (i != skip && key_state[i] == KS_PRESSED && key_kind_tbl[i] == KIND_DUAL &&
          age >= limit) begin
        key_kind_tbl[i] = KIND_HOLD;
        if (open_duals > 0) open_duals--;
        note_change(i, CHG_HOLD, 1'b0);
      end
    end
  endfunction

  // Apply one accepted event to the shadow state and collect its changes.
  // Returns whether the event had any effect.
  function automatic bit resolve_event(input thkr_in_t ev);
    logic [2:0] kind;
    logic [7:0] age;
    logic       emit;
    int         s;
    bit         took;
    kind = (ev.key_kind > KIND_DUAL) ? KIND_NORMAL : ev.key_kind;
    s    = ev.key_slot;
    emit = 1'b0;
    took = 1'b0;
    run_changes.delete();
    case (ev.func)
      FUNC_TICK: begin
        now_ticks = now_ticks + 8'd1;
        promote_duals(hold_limit, KEY_SLOTS);
        took = 1'b1;
      end
      FUNC_PRESS: begin
        if (key_state[s] != KS_PRESSED && key_state[s] != KS_REPEAT) begin
          took = 1'b1;
          if (kind != KIND_DUAL) promote_duals(8'd0, KEY_SLOTS);
          keys_down++;
          key_state[s]    = KS_PRESSED;
          key_kind_tbl[s] = kind;
          key_stamp[s]    = now_ticks;
          key_code_tbl[s] = ev.key_code;
          if (kind == KIND_DUAL) begin
            age = now_ticks - last_tap_tick;
            if (tapped && released_code == ev.key_code && age < repeat_limit) begin
              key_state[s]    = KS_REPEAT;
              key_kind_tbl[s] = KIND_REPEAT;
            end else begin
              open_duals++;
            end
          end
          emit = (open_duals == 0) &&
                 (key_kind_tbl[s] <= KIND_NORMAL_MOD || key_state[s] == KS_REPEAT);
          note_change(s, CHG_PRESSED, emit);
        end
      end
      FUNC_RELEASE: begin
        if (key_state[s] == KS_PRESSED || key_state[s] == KS_REPEAT) begin
          took = 1'b1;
          released_code = key_code_tbl[s];
          if (keys_down > 0) keys_down--;
          if (key_state[s] == KS_PRESSED && key_kind_tbl[s] == KIND_DUAL) begin
            if (open_duals > 0) open_duals--;
            age = now_ticks - key_stamp[s];
            if (age < hold_limit) begin
              // A quick release is a tap and decides every other pending dual.
              key_state[s]    = KS_TAP;
              key_kind_tbl[s] = KIND_TAP;
              promote_duals(8'd0, s);
              last_tap_tick = now_ticks;
              tapped        = 1'b1;
              emit          = 1'b1;
            end else begin
              key_state[s] = KS_RELEASED;
            end
          end else begin
            key_state[s] = KS_RELEASED;
          end
          note_change(s, CHG_RELEASED, emit);
        end
      end
      default: begin
      end
    endcase
    if (run_changes.size() > 0) run_changes[run_changes.size() - 1].last_of_run = 1'b1;
    return took;
  endfunction

  // Random event shaped by the shadow state: mostly presses of free slots,
  // releases of held ones and ticks, with some noise.
  function automatic thkr_in_t pick_event();
    thkr_in_t ev;
    int       roll;
    int       held[$];
    ev   = thkr_in_t'($urandom);
    roll = $urandom_range(0, 99);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (key_state[i] == KS_PRESSED || key_state[i] == KS_REPEAT) held.push_back(i);
    end
    if (roll < 4) begin
      ev.func = FUNC_NONE;
    end else if (roll < 8) begin
      ev.func = FUNC_RELEASE;
    end else if (roll < 33) begin
      ev.func = FUNC_TICK;
    end else if ((roll < 66 && held.size() < 8) || held.size() == 0) begin
      ev.func = FUNC_PRESS;
      repeat (3) begin
        if (key_state[ev.key_slot] == KS_PRESSED || key_state[ev.key_slot] == KS_REPEAT)
          ev.key_slot = 5'($urandom);
      end
      if ($urandom_range(0, 1) == 1) ev.key_kind = KIND_DUAL;
      // Reuse the last released code now and then to reach repeat presses.
      if (ev.key_kind == KIND_DUAL && tapped && $urandom_range(0, 1) == 1)
        ev.key_code = released_code;
    end else begin
      ev.func     = FUNC_RELEASE;
      ev.key_slot = 5'(held[$urandom_range(0, held.size() - 1)]);
    end
    return ev;
  endfunction

  function automatic string show(input thkr_out_t r);
    return $sformatf("slot=%0d chg=%0d kind=%0d status=%0d emit=%0d held=%0d last=%0d",
                     r.out_slot, r.change_kind, r.resolved_kind, r.key_status, r.emit,
                     r.held_count, r.last_of_run);
  endfunction

  // Offer one input beat, wait for it to be taken and queue its results.
  task automatic offer_event(input thkr_in_t ev, input bit typed, input thkr_out_t want,
                             output bit took);
    while (tx_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    took = resolve_event(ev);
    if (typed) begin
      pending_changes.push_back(want);
    end else begin
      foreach (run_changes[i]) pending_changes.push_back(run_changes[i]);
    end
  endtask

  // Stop sending, wait for every queued result, then let the block settle.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_changes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one timeout register, mirror it and read it back.
  task automatic set_timeout(input logic idx, input logic [7:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, {idx, 2'b00}, {24'd0, val}, rd);
    if (idx == REG_HOLD_TIMEOUT) hold_limit = val;
    else repeat_limit = val;
    apb_xfer(1'b0, {idx, 2'b00}, 32'd0, rd);
    if (rd !== {24'd0, val}) begin
      errors++;
      $display("%0t: register %0d readback expected %0d, got %0d", $time, idx, val, rd);
    end
  endtask

  task automatic release_all_held();
    bit took;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (key_state[i] == KS_PRESSED || key_state[i] == KS_REPEAT)
        offer_event({FUNC_RELEASE, 5'(i), KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT, took);
    end
  endtask

  task automatic random_run(input int n);
    int  done;
    bit  took;
    done = 0;
    while (done < n) begin
      offer_event(pick_event(), 1'b0, NO_RESULT, took);
      if (took) done++;
    end
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(rx_idle && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Compare every result beat against the oldest expectation.
  always @(posedge clk) begin
    thkr_out_t want;
    if (out_valid && out_ready) begin
      if (pending_changes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %s", $time, show(out_data));
      end else begin
        want = pending_changes.pop_front();
        if (out_data !== want) begin
          errors++;
          $display("%0t: result mismatch, expected %s, got %s", $time, show(want),
                   show(out_data));
        end
      end
    end
  end

  // Cycle limit for the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_tap_hold_key_resolver failed");
    $finish;
  end

  initial begin
    bit took;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    errors        = 0;
    hold_off_left = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      key_state[i]    = KS_IDLE;
      key_kind_tbl[i] = KIND_NORMAL;
      key_stamp[i]    = 8'd0;
      key_code_tbl[i] = 8'd0;
    end
    now_ticks     = 8'd0;
    keys_down     = 0;
    open_duals    = 0;
    released_code = 8'd0;
    last_tap_tick = 8'd0;
    tapped        = 1'b0;
    hold_limit    = 8'd3;
    repeat_limit  = 8'd3;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events at the reset timeouts.
    // Normal key press and release, with the code at its low extreme.
    dir_rows.push_back({{FUNC_PRESS, 5'd0, KIND_NORMAL, 8'h00}, 1'b1,
                        {5'd0, CHG_PRESSED, KIND_NORMAL, RS_PRESSED, 1'b1, 6'd1, 1'b1}});
    dir_rows.push_back({{FUNC_RELEASE, 5'd0, KIND_NORMAL, 8'h00}, 1'b1,
                        {5'd0, CHG_RELEASED, KIND_NORMAL, RS_RELEASED, 1'b0, 6'd0, 1'b1}});
    // Dual on the top slot, tapped after one tick, then pressed again as repeat.
    dir_rows.push_back({{FUNC_PRESS, 5'd31, KIND_DUAL, 8'hFF}, 1'b1,
                        {5'd31, CHG_PRESSED, KIND_DUAL, RS_PRESSED, 1'b0, 6'd1, 1'b1}});
    dir_rows.push_back({{FUNC_TICK, 5'd0, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_RELEASE, 5'd31, KIND_NORMAL, 8'h00}, 1'b1,
                        {5'd31, CHG_RELEASED, KIND_TAP, RS_TAP, 1'b1, 6'd0, 1'b1}});
    dir_rows.push_back({{FUNC_PRESS, 5'd31, KIND_DUAL, 8'hFF}, 1'b1,
                        {5'd31, CHG_PRESSED, KIND_REPEAT, RS_REPEAT, 1'b1, 6'd1, 1'b1}});
    dir_rows.push_back({{FUNC_RELEASE, 5'd31, KIND_NORMAL, 8'h00}, 1'b1,
                        {5'd31, CHG_RELEASED, KIND_REPEAT, RS_RELEASED, 1'b0, 6'd0, 1'b1}});
    // Two duals forced to hold by a modifier-normal press.
    dir_rows.push_back({{FUNC_PRESS, 5'd5, KIND_DUAL, 8'h11}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_PRESS, 5'd6, KIND_DUAL, 8'h22}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_PRESS, 5'd7, KIND_NORMAL_MOD, 8'h33}, 1'b0, NO_RESULT});
    // Press of a slot already held is ignored.
    dir_rows.push_back({{FUNC_PRESS, 5'd7, KIND_MODIFIER, 8'h44}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_RELEASE, 5'd7, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_RELEASE, 5'd5, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_RELEASE, 5'd6, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    // Release of a slot not held is ignored.
    dir_rows.push_back({{FUNC_RELEASE, 5'd6, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    // A tap decides the other pending dual as hold.
    dir_rows.push_back({{FUNC_PRESS, 5'd10, KIND_DUAL, 8'h55}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_PRESS, 5'd11, KIND_DUAL, 8'h66}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_RELEASE, 5'd10, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_RELEASE, 5'd11, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    // Layer key, a kind above dual taken as normal, and an unused function.
    dir_rows.push_back({{FUNC_PRESS, 5'd12, KIND_LAYER, 8'h77}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_PRESS, 5'd13, KIND_HOLD, 8'h88}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_NONE, 5'd13, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    // A dual that times out to hold on the third tick.
    dir_rows.push_back({{FUNC_PRESS, 5'd14, KIND_DUAL, 8'h99}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_TICK, 5'd0, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_TICK, 5'd0, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    dir_rows.push_back({{FUNC_TICK, 5'd0, KIND_NORMAL, 8'h00}, 1'b0, NO_RESULT});
    foreach (dir_rows[i]) offer_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want, took);

    // Immediate hold, very long repeat window.
    wait_results_done();
    set_timeout(REG_HOLD_TIMEOUT, 8'd0);
    set_timeout(REG_REPEAT_TIMEOUT, 8'd255);
    random_run(15);

    // Longest hold, no repeat, no idling on either side. One dual is held
    // across a run of ticks that stays well short of the timeout.
    wait_results_done();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_timeout(REG_HOLD_TIMEOUT, 8'd255);
    set_timeout(REG_REPEAT_TIMEOUT, 8'd0);
    release_all_held();
    offer_event({FUNC_PRESS, 5'd20, KIND_DUAL, 8'hA5}, 1'b0, NO_RESULT, took);
    repeat (12) begin
      offer_event({FUNC_TICK, 5'($urandom), 3'($urandom), 8'($urandom)}, 1'b0, NO_RESULT,
                  took);
    end
    random_run(15);

    // Fill the whole table while the result side holds off, so the block
    // backs up; the last press turns all 31 duals into hold keys.
    wait_results_done();
    rx_idle = 1'b1;
    set_timeout(REG_HOLD_TIMEOUT, 8'd2);
    set_timeout(REG_REPEAT_TIMEOUT, 8'd5);
    release_all_held();
    hold_off_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      offer_event({FUNC_PRESS, 5'(i), (i == KEY_SLOTS - 1) ? KIND_NORMAL : KIND_DUAL,
                   8'($urandom)}, 1'b0, NO_RESULT, took);
    end
    release_all_held();

    // Random short timeouts with idling on both sides.
    wait_results_done();
    tx_idle = 1'b1;
    set_timeout(REG_HOLD_TIMEOUT, 8'($urandom_range(1, 6)));
    set_timeout(REG_REPEAT_TIMEOUT, 8'($urandom_range(1, 6)));
    random_run(20);

    wait_results_done();
    if (errors == 0) begin
      $display("tb_tap_hold_key_resolver passed");
    end else begin
      $display("tb_tap_hold_key_resolver failed");
    end
    $finish;
  end

endmodule
